// File: hw/rtl/assert_macros.svh
// assertion macros shared by the queue and loop update modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// File: hw/rtl/clt_pkg.sv
// shared types and constants of the costas loop carrier tracker
package clt_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned GainW   = 25;
  localparam int unsigned LimitW  = 31;
  localparam int unsigned ErrW    = 18;
  localparam int unsigned PhaseW  = 32;
  localparam int unsigned FreqW   = 31;
  localparam int unsigned StepW   = 32;
  localparam int unsigned ProdW   = 44;
  localparam int unsigned GainShift = 11;
  localparam int unsigned FreqSumW  = 34;
  localparam int unsigned PhaseSumW = 35;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned CfgDataW = 31;

  // register indexes of the configuration port
  typedef enum logic [CfgAddrW-1:0] {
    CFG_PROP_GAIN  = 2'd0,
    CFG_INT_GAIN   = 2'd1,
    CFG_UPPER_FREQ = 2'd2,
    CFG_LOWER_FREQ = 2'd3
  } cfg_reg_e;

  // 2pi in q3.28 and its multiples used by the wrap
  localparam logic signed [PhaseW-1:0]    TwoPi   = 32'sd1686629713;
  localparam logic signed [PhaseSumW-1:0] TwoPi1x = 35'sd1686629713;
  localparam logic signed [PhaseSumW-1:0] TwoPi2x = 35'sd3373259426;
  localparam logic signed [PhaseSumW-1:0] TwoPi3x = 35'sd5059889139;

  localparam logic signed [ProdW-1:0] RoundHalf = 44'sd1024;

  localparam logic signed [LimitW-1:0] UpperFreqReset = 31'sd268435456;
  localparam logic signed [LimitW-1:0] LowerFreqReset = -31'sd268435456;

  // one classified sample waiting for the loop update
  typedef struct packed {
    logic signed [ErrW-1:0]  err;
    logic signed [StepW-1:0] prop_step;
    logic signed [StepW-1:0] int_step;
  } q_entry_t;

  // loop limits handed to the update stage
  typedef struct packed {
    logic signed [LimitW-1:0] upper;
    logic signed [LimitW-1:0] lower;
  } freq_limits_t;

endpackage

// File: hw/rtl/clt_front.sv
// detector and gain multiplies: error sign logic, products, rounding into the queue
module clt_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [clt_pkg::SampleW-1:0]  sample_re_i,
  input  logic signed [clt_pkg::SampleW-1:0]  sample_im_i,
  input  logic        [clt_pkg::GainW-1:0]    prop_gain_i,
  input  logic        [clt_pkg::GainW-1:0]    int_gain_i,
  output logic                                push_valid_o,
  input  logic                                push_ready_i,
  output clt_pkg::q_entry_t                   push_data_o
);
  import clt_pkg::*;

  logic                    vld_q, vld_d;
  logic signed [ErrW-1:0]  err_q, err_d;
  logic signed [ProdW-1:0] prop_prod_q, prop_prod_d;
  logic signed [ProdW-1:0] int_prod_q, int_prod_d;
  logic signed [ProdW-1:0] prop_rnd, int_rnd;
  logic signed [SampleW:0] re_ext, im_ext, term_a, term_b;
  logic                    accept;

  assign re_ext = (SampleW+1)'(sample_re_i);
  assign im_ext = (SampleW+1)'(sample_im_i);

  // zero counts as negative
  assign term_a = (sample_re_i > 0) ? im_ext : -im_ext;
  assign term_b = (sample_im_i > 0) ? re_ext : -re_ext;
  assign err_d  = ErrW'(term_a) - ErrW'(term_b);

  assign prop_prod_d = ProdW'(err_d) * ProdW'($signed({1'b0, prop_gain_i}));
  assign int_prod_d  = ProdW'(err_d) * ProdW'($signed({1'b0, int_gain_i}));

  assign in_ready_o = !vld_q || push_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      err_q       <= err_d;
      prop_prod_q <= prop_prod_d;
      int_prod_q  <= int_prod_d;
    end
  end

  // round to nearest, ties up, then drop eleven bits
  assign prop_rnd = prop_prod_q + RoundHalf;
  assign int_rnd  = int_prod_q + RoundHalf;

  assign push_valid_o          = vld_q;
  assign push_data_o.err       = err_q;
  assign push_data_o.prop_step = prop_rnd[StepW+GainShift-1:GainShift];
  assign push_data_o.int_step  = int_rnd[StepW+GainShift-1:GainShift];

endmodule

// File: hw/rtl/clt_queue.sv
// two-entry queue between the detector and the loop update
`include "assert_macros.svh"

module clt_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  output logic              push_ready_o,
  input  clt_pkg::q_entry_t push_data_i,
  output logic              pop_valid_o,
  input  logic              pop_ready_i,
  output clt_pkg::q_entry_t pop_data_o
);
  import clt_pkg::*;

  q_entry_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueueCntW-1:0]   count_q, count_d;
  logic                   push, pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QueuePtrW'(QueueDepth-1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QueuePtrW'(QueueDepth-1)) ? '0 : rd_ptr_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `ASSERT_IMPLIES(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= QueueCntW'(QueueDepth), "queue count above depth")
  `ASSERT_NEXT(a_push_only_grows, clk_i, rst_ni, push && !pop, count_q == $past(count_q) + 1'b1, "push lost in queue count")

endmodule

// File: hw/rtl/clt_back.sv
// loop update: frequency and phase accumulators, phase wrap, frequency clamp, output register
`include "assert_macros.svh"

module clt_back (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                pop_valid_i,
  output logic                                pop_ready_o,
  input  clt_pkg::q_entry_t                   pop_data_i,
  input  clt_pkg::freq_limits_t               limits_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [clt_pkg::ErrW-1:0]     phase_error_o,
  output logic signed [clt_pkg::PhaseW-1:0]   loop_phase_o,
  output logic signed [clt_pkg::FreqW-1:0]    loop_frequency_o
);
  import clt_pkg::*;

  logic signed [PhaseW-1:0]    phase_acc_q, phase_acc_d;
  logic signed [FreqW-1:0]     freq_acc_q, freq_acc_d;
  logic signed [FreqSumW-1:0]  freq_raw, upper_ext, lower_ext;
  logic signed [PhaseSumW-1:0] phase_raw, phase_wrapped;
  logic                        out_vld_q, out_vld_d;
  logic signed [ErrW-1:0]      out_err_q;
  logic signed [PhaseW-1:0]    out_phase_q;
  logic signed [FreqW-1:0]     out_freq_q;
  logic                        pop;

  assign pop_ready_o = !out_vld_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  assign freq_raw  = FreqSumW'(freq_acc_q) + FreqSumW'(pop_data_i.int_step);
  assign phase_raw = PhaseSumW'(phase_acc_q) + PhaseSumW'(freq_acc_q)
                   + PhaseSumW'(pop_data_i.int_step) + PhaseSumW'(pop_data_i.prop_step);

  // wrap into [-2pi, 2pi], at most three turns
  always_comb begin
    priority if (phase_raw > TwoPi3x) begin
      phase_wrapped = phase_raw - TwoPi3x;
    end else if (phase_raw > TwoPi2x) begin
      phase_wrapped = phase_raw - TwoPi2x;
    end else if (phase_raw > TwoPi1x) begin
      phase_wrapped = phase_raw - TwoPi1x;
    end else if (phase_raw < -TwoPi3x) begin
      phase_wrapped = phase_raw + TwoPi3x;
    end else if (phase_raw < -TwoPi2x) begin
      phase_wrapped = phase_raw + TwoPi2x;
    end else if (phase_raw < -TwoPi1x) begin
      phase_wrapped = phase_raw + TwoPi1x;
    end else begin
      phase_wrapped = phase_raw;
    end
  end

  assign upper_ext = FreqSumW'(limits_i.upper);
  assign lower_ext = FreqSumW'(limits_i.lower);

  // upper limit is checked first: with inverted limits a sum above it takes the upper limit, any other sum the lower
  always_comb begin
    priority if (freq_raw > upper_ext) begin
      freq_acc_d = limits_i.upper;
    end else if (freq_raw < lower_ext) begin
      freq_acc_d = limits_i.lower;
    end else begin
      freq_acc_d = freq_raw[FreqW-1:0];
    end
  end

  assign phase_acc_d = phase_wrapped[PhaseW-1:0];

  always_comb begin
    out_vld_d = out_vld_q;
    if (pop) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q   <= 1'b0;
      phase_acc_q <= '0;
      freq_acc_q  <= '0;
    end else begin
      out_vld_q <= out_vld_d;
      if (pop) begin
        phase_acc_q <= phase_acc_d;
        freq_acc_q  <= freq_acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_err_q   <= pop_data_i.err;
      out_phase_q <= phase_acc_d;
      out_freq_q  <= freq_acc_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign phase_error_o    = out_err_q;
  assign loop_phase_o     = out_phase_q;
  assign loop_frequency_o = out_freq_q;

  `ASSERT_IMPLIES(a_phase_wrapped, clk_i, rst_ni, out_vld_q, (out_phase_q <= TwoPi) && (out_phase_q >= -TwoPi), "phase left the wrap range")
  `ASSERT_NEXT(a_pop_loads_out, clk_i, rst_ni, pop, out_vld_q && (out_phase_q == phase_acc_q), "update not shown at output")
  `ASSERT_NEXT(a_stall_holds_acc, clk_i, rst_ni, out_vld_q && !out_ready_i, $stable(phase_acc_q) && $stable(freq_acc_q), "accumulators moved during stall")

endmodule

// File: hw/rtl/costas_loop_carrier_tracker_unit.sv
// top level of the qpsk costas loop carrier tracker
//
//  channel  | direction | width        | contents
//  ---------+-----------+--------------+------------------------------------------
//  s_axis   | in        | 32 bit tdata | derotated sample, re and im in q1.15
//  m_axis   | out       | 88 bit tdata | error q2.15, phase q3.28, frequency q3.28
//  cfg      | in        | 2 + 31 bit   | gains and frequency limits, write only
//
//  one sample per clock sustained while m_axis_tready stays high; a transfer in passes the
//  detector/multiply register, the two-entry queue and the output register
//  the loop update is combinational between the accumulator registers: four-input add, wrap compare and subtract
//  reset clears both accumulators, the queue and all valid flags; gains reset to zero,
//  limits to +1.0 and -1.0 rad/sample
//  a stall at m_axis fills the queue, then holds s_axis_tready low
module costas_loop_carrier_tracker_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave stream: [15:0] sample_re, [31:16] sample_im
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,
  // master stream: [17:0] phase_error, [49:18] loop_phase, [80:50] loop_frequency,
  // [87:81] zero
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [87:0]                      m_axis_tdata,
  // configuration writes
  input  logic                             cfg_we_i,
  input  logic [clt_pkg::CfgAddrW-1:0]     cfg_addr_i,
  input  logic [clt_pkg::CfgDataW-1:0]     cfg_wdata_i
);
  import clt_pkg::*;

  // configuration registers
  logic [GainW-1:0]  prop_gain_q, int_gain_q;
  freq_limits_t      limits_q;

  // front to queue
  logic     push_valid, push_ready;
  q_entry_t push_data;

  // queue to back
  logic     pop_valid, pop_ready;
  q_entry_t pop_data;

  // result fields
  logic signed [ErrW-1:0]   phase_error;
  logic signed [PhaseW-1:0] loop_phase;
  logic signed [FreqW-1:0]  loop_frequency;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q    <= '0;
      int_gain_q     <= '0;
      limits_q.upper <= UpperFreqReset;
      limits_q.lower <= LowerFreqReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        CFG_PROP_GAIN:  prop_gain_q    <= cfg_wdata_i[GainW-1:0];
        CFG_INT_GAIN:   int_gain_q     <= cfg_wdata_i[GainW-1:0];
        CFG_UPPER_FREQ: limits_q.upper <= $signed(cfg_wdata_i[LimitW-1:0]);
        CFG_LOWER_FREQ: limits_q.lower <= $signed(cfg_wdata_i[LimitW-1:0]);
        default: ;
      endcase
    end
  end

  // detector and gain products
  clt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .sample_re_i  ($signed(s_axis_tdata[15:0])),
    .sample_im_i  ($signed(s_axis_tdata[31:16])),
    .prop_gain_i  (prop_gain_q),
    .int_gain_i   (int_gain_q),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // decouples the detector from the loop update
  clt_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // accumulators, wrap, clamp, output register
  clt_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .pop_valid_i      (pop_valid),
    .pop_ready_o      (pop_ready),
    .pop_data_i       (pop_data),
    .limits_i         (limits_q),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .phase_error_o    (phase_error),
    .loop_phase_o     (loop_phase),
    .loop_frequency_o (loop_frequency)
  );

  // pack result fields, lowest field first, zero pad to whole bytes
  assign m_axis_tdata = {7'd0, loop_frequency, loop_phase, phase_error};

endmodule
